/* rtl/hcsm_pkg.sv */
package hcsm_pkg;

    localparam int HALL_W     = 3;
    localparam int OVR_W      = 16;
    localparam int AVG_OUT_W  = 16;
    localparam int SPEED_W    = 24;
    localparam int PP_W       = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE_PAIRS     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_POSITION = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CONSTANT = 8'd3;

    localparam logic [PP_W-1:0]    POLE_PAIRS_RST     = 8'd2;
    localparam logic [HALL_W-1:0]  INDEX_POSITION_RST = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_CONSTANT_RST = 24'd2343750;
    localparam logic [PP_W-1:0]    INDEX_COUNT_RST    = 8'd1;

    // The divider quotient is scaled down by this factor to give the speed.
    localparam int SPEED_SCALE = 12;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_HALL = 1'b1;

    localparam logic DIR_CW  = 1'b0;

    // Six-step override patterns; hall codes 0 and 7 are invalid and give no drive.
    function automatic logic [OVR_W-1:0] override_lookup(input logic dir,
                                                         input logic [HALL_W-1:0] hall);
        logic [OVR_W-1:0] cw;
        logic [OVR_W-1:0] acw;
        case (hall)
            3'd1: begin cw = 16'h0210; acw = 16'h2001; end
            3'd2: begin cw = 16'h2004; acw = 16'h0810; end
            3'd3: begin cw = 16'h0204; acw = 16'h0801; end
            3'd4: begin cw = 16'h0801; acw = 16'h0204; end
            3'd5: begin cw = 16'h0810; acw = 16'h2004; end
            3'd6: begin cw = 16'h2001; acw = 16'h0210; end
            default: begin cw = 16'h0000; acw = 16'h0000; end
        endcase
        return (dir == DIR_CW) ? cw : acw;
    endfunction

endpackage

/* rtl/hcsm_if.sv */
interface hcsm_in_if import hcsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [HALL_W-1:0] hall_bits;

    modport source (output valid, mode, hall_bits, input ready);
    modport sink   (input valid, mode, hall_bits, output ready);
endinterface

interface hcsm_out_if import hcsm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OVR_W-1:0]     override_word;
    logic [AVG_OUT_W-1:0] period_average;
    logic [SPEED_W-1:0]   speed_value;
    logic                 speed_valid;
    logic                 revolution_done;

    modport source (output valid, override_word, period_average, speed_value, speed_valid,
                    revolution_done, input ready);
    modport sink   (input valid, override_word, period_average, speed_value, speed_valid,
                    revolution_done, output ready);
endinterface

interface hcsm_cfg_if import hcsm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/hall_commutation_speed_meter_top.sv */
// Six-step hall commutation with revolution timing and speed calculation.
// Input channel i_in: each beat is a timer tick (mode 0) or a hall change (mode 1)
// with the three hall levels. Output channel o_out: one result beat per input beat,
// carrying the override word, the averaged period, the speed and two flags.
// Configuration channel i_cfg: always ready; index 0 direction, 1 pole pairs,
// 2 index position, 3 speed constant. Other indexes are ignored.
// A tick, or a hall beat that does not complete a revolution, gives its result in the
// cycle after acceptance, so ticks can follow one per cycle while the receiver keeps up.
// A revolution capture with a nonzero average runs a restoring divider for
// constant / average, one quotient bit per cycle in the divide state, then divides the
// quotient by twelve with a shift and a reciprocal multiplication in the scale state,
// which registers the result. A capture with a zero average gives its result in the
// cycle after acceptance.
// One beat is in flight at a time: i_in.ready is high only while the sequencer is idle
// and the output register is empty or being emptied in the same cycle.
// When the receiver stalls, the result is held and no further beat is accepted.
// Synchronous reset clears the period counter, average, held speed and override, sets
// the index count to one, restores the register defaults and empties the output register.
module hall_commutation_speed_meter_top import hcsm_pkg::*; #(
    parameter int COUNTER_BITS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    hcsm_in_if.sink     i_in,
    hcsm_out_if.source  o_out,
    hcsm_cfg_if.sink    i_cfg
);

    localparam int STEP_W = $clog2(SPEED_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SPEED_W - 1);

    // Division by twelve: drop two bits, then multiply by the rounded-up reciprocal
    // of three scaled by two to the power of RECIP_SHIFT.
    localparam int QUOT_W      = SPEED_W - 2;
    localparam int RECIP_SHIFT = QUOT_W + 1;
    localparam logic [QUOT_W-1:0] THIRD_RECIP = QUOT_W'(2796203);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_SCALE = 2'd2;

    logic                    r_direction;
    logic [PP_W-1:0]         r_pole_pairs;
    logic [HALL_W-1:0]       r_index_position;
    logic [SPEED_W-1:0]      r_speed_constant;

    logic [COUNTER_BITS-1:0] r_period_counter, n_period_counter;
    logic [PP_W-1:0]         r_index_count, n_index_count;
    logic [COUNTER_BITS-1:0] r_average, n_average;
    logic [SPEED_W-1:0]      r_held_speed, n_held_speed;
    logic [OVR_W-1:0]        r_held_override, n_held_override;

    logic [1:0]              r_state, n_state;
    logic [STEP_W-1:0]       r_step, n_step;
    logic [SPEED_W-1:0]      r_num, n_num;
    logic [COUNTER_BITS-1:0] r_rem, n_rem;
    logic [COUNTER_BITS-1:0] r_div, n_div;
    logic                    r_out_valid, n_out_valid;
    logic                    r_done, n_done;

    logic                    in_fire;
    logic                    capture;
    logic [COUNTER_BITS:0]   sum;
    logic [COUNTER_BITS-1:0] new_average;
    logic [COUNTER_BITS:0]   rem_sh;
    logic                    rem_geq;
    logic [COUNTER_BITS:0]   rem_diff;
    logic [2*QUOT_W-1:0]     scale_prod;
    logic [COUNTER_BITS+AVG_OUT_W-1:0] avg_ext;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_fire     = i_in.valid && i_in.ready;

    assign capture = (i_in.mode == MODE_HALL) && (i_in.hall_bits == r_index_position)
                     && (r_index_count == r_pole_pairs);
    assign sum         = {1'b0, r_average} + {1'b0, r_period_counter};
    assign new_average = sum[COUNTER_BITS:1];

    // Divider step: one restoring subtract per cycle.
    assign rem_sh   = {r_rem, r_num[SPEED_W-1]};
    assign rem_geq  = rem_sh >= {1'b0, r_div};
    assign rem_diff = rem_sh - {1'b0, r_div};

    assign scale_prod = r_num[SPEED_W-1:2] * THIRD_RECIP;

    always_comb begin
        n_period_counter = r_period_counter;
        n_index_count    = r_index_count;
        n_average        = r_average;
        n_held_speed     = r_held_speed;
        n_held_override  = r_held_override;
        n_state          = r_state;
        n_step           = r_step;
        n_num            = r_num;
        n_rem            = r_rem;
        n_div            = r_div;
        n_out_valid      = r_out_valid;
        n_done           = r_done;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_done = 1'b0;
                    if (i_in.mode == MODE_TICK) begin
                        n_period_counter = r_period_counter + 1'b1;
                        n_out_valid      = 1'b1;
                    end else begin
                        n_held_override = override_lookup(r_direction, i_in.hall_bits);
                        if (capture) begin
                            n_period_counter = '0;
                            n_average        = new_average;
                            n_index_count    = INDEX_COUNT_RST;
                            n_done           = 1'b1;
                            if (new_average == '0) begin
                                n_held_speed = '0;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_num   = r_speed_constant;
                                n_rem   = '0;
                                n_div   = new_average;
                                n_step  = '0;
                                n_state = ST_DIV;
                            end
                        end else begin
                            if (i_in.hall_bits == r_index_position) begin
                                n_index_count = r_index_count + 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_num  = {r_num[SPEED_W-2:0], rem_geq};
                n_rem  = rem_geq ? rem_diff[COUNTER_BITS-1:0] : rem_sh[COUNTER_BITS-1:0];
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_held_speed = SPEED_W'(scale_prod[2*QUOT_W-1:RECIP_SHIFT]);
                n_out_valid  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction      <= DIR_CW;
            r_pole_pairs     <= POLE_PAIRS_RST;
            r_index_position <= INDEX_POSITION_RST;
            r_speed_constant <= SPEED_CONSTANT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DIRECTION:      r_direction      <= i_cfg.data[0];
                REG_POLE_PAIRS:     r_pole_pairs     <= i_cfg.data[PP_W-1:0];
                REG_INDEX_POSITION: r_index_position <= i_cfg.data[HALL_W-1:0];
                REG_SPEED_CONSTANT: r_speed_constant <= i_cfg.data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_counter <= '0;
            r_index_count    <= INDEX_COUNT_RST;
            r_average        <= '0;
            r_held_speed     <= '0;
            r_held_override  <= '0;
            r_state          <= ST_IDLE;
            r_step           <= '0;
            r_out_valid      <= 1'b0;
            r_done           <= 1'b0;
        end else begin
            r_period_counter <= n_period_counter;
            r_index_count    <= n_index_count;
            r_average        <= n_average;
            r_held_speed     <= n_held_speed;
            r_held_override  <= n_held_override;
            r_state          <= n_state;
            r_step           <= n_step;
            r_out_valid      <= n_out_valid;
            r_done           <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign avg_ext = {{AVG_OUT_W{1'b0}}, r_average};

    assign o_out.valid           = r_out_valid;
    assign o_out.override_word   = r_held_override;
    assign o_out.period_average  = avg_ext[AVG_OUT_W-1:0];
    assign o_out.speed_value     = r_held_speed;
    assign o_out.speed_valid     = (r_average != '0);
    assign o_out.revolution_done = r_done;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import hcsm_pkg::*;

    localparam int CNT_W        = 16;
    localparam int IDLE_LIMIT   = 2000;
    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE       = 60;

    localparam logic DIR_ACW = 1'b1;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 8'hFF;

    // Override words packed by hall code, code 0 in the lowest slice.
    localparam logic [8*OVR_W-1:0] CW_DRIVE  = {16'h0000, 16'h2001, 16'h0810, 16'h0801,
                                                16'h0204, 16'h2004, 16'h0210, 16'h0000};
    localparam logic [8*OVR_W-1:0] ACW_DRIVE = {16'h0000, 16'h0210, 16'h2004, 16'h0204,
                                                16'h0801, 16'h0810, 16'h2001, 16'h0000};
    // Valid hall codes in the order a turning rotor presents them.
    localparam logic [6*HALL_W-1:0] ROTATION = {3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd5};

    localparam logic [SPEED_W-1:0] K_DEFAULT = 24'd2343750;
    localparam logic [SPEED_W-1:0] K_MAX     = '1;

    typedef struct packed {
        logic              mode;
        logic [HALL_W-1:0] hall;
        logic [2:0]        gap;
    } hall_beat_t;

    typedef struct packed {
        logic [OVR_W-1:0]     override_word;
        logic [AVG_OUT_W-1:0] period_average;
        logic [SPEED_W-1:0]   speed_value;
        logic                 speed_valid;
        logic                 revolution_done;
    } motor_status_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hcsm_in_if  in_bus ();
    hcsm_out_if out_bus ();
    hcsm_cfg_if cfg_bus ();

    hall_commutation_speed_meter_top #(.COUNTER_BITS(CNT_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Own copy of the configuration and of the motor timing state.
    logic               cfg_dir;
    logic [PP_W-1:0]    cfg_pole_pairs;
    logic [HALL_W-1:0]  cfg_index_code;
    logic [SPEED_W-1:0] cfg_speed_k;
    logic [CNT_W-1:0]   tick_count;
    logic [PP_W-1:0]    visit_count;
    logic [CNT_W-1:0]   avg_period;
    logic [SPEED_W-1:0] speed_hold;
    logic [OVR_W-1:0]   drive_word;

    hall_beat_t    beat_queue[$];
    motor_status_t status_expected[$];

    hall_beat_t staged_beat;
    bit         drv_staged  = 1'b0;
    int         gap_left    = 0;
    int         stall_left  = 0;
    bit         steady_flow = 1'b0;
    bit         in_fired    = 1'b0;
    bit         out_fired   = 1'b0;
    bit         cfg_fired   = 1'b0;

    int idle_cycles     = 0;
    int fault_count     = 0;
    int beats_accepted  = 0;
    int results_checked = 0;
    int captures_seen   = 0;
    int cfg_writes      = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic motor_status_t commutate(input logic mode,
                                                input logic [HALL_W-1:0] hall);
        logic [CNT_W:0]  period_sum;
        logic [PP_W-1:0] visits_before;
        logic            captured;
        captured = 1'b0;
        if (mode == MODE_TICK) begin
            tick_count = tick_count + 1'b1;
        end else begin
            drive_word = (cfg_dir == DIR_CW) ? CW_DRIVE[hall*OVR_W +: OVR_W]
                                             : ACW_DRIVE[hall*OVR_W +: OVR_W];
            if (hall == cfg_index_code) begin
                visits_before = visit_count;
                visit_count   = visit_count + 1'b1;
                if (visits_before == cfg_pole_pairs) begin
                    // The sum keeps its carry so a wrapped-looking total still halves right.
                    period_sum  = {1'b0, avg_period} + {1'b0, tick_count};
                    avg_period  = period_sum[CNT_W:1];
                    tick_count  = '0;
                    visit_count = 8'd1;
                    if (avg_period == '0) begin
                        speed_hold = '0;
                    end else begin
                        speed_hold = SPEED_W'((cfg_speed_k / avg_period) / SPEED_SCALE);
                    end
                    captured = 1'b1;
                end
            end
        end
        return '{drive_word, avg_period, speed_hold, avg_period != '0, captured};
    endfunction

    // Handshakes, prediction, checking and the watchdog, all on the rising edge.
    always @(posedge i_clk) begin
        motor_status_t want;
        motor_status_t got;
        in_fired  = i_rst_n && in_bus.valid && in_bus.ready;
        out_fired = i_rst_n && out_bus.valid && out_bus.ready;
        cfg_fired = i_rst_n && cfg_bus.valid && cfg_bus.ready;
        if (cfg_fired) begin
            case (cfg_bus.index)
                REG_DIRECTION:      cfg_dir        = cfg_bus.data[0];
                REG_POLE_PAIRS:     cfg_pole_pairs = cfg_bus.data[PP_W-1:0];
                REG_INDEX_POSITION: cfg_index_code = cfg_bus.data[HALL_W-1:0];
                REG_SPEED_CONSTANT: cfg_speed_k    = cfg_bus.data[SPEED_W-1:0];
                default: ;
            endcase
            cfg_writes++;
        end
        if (in_fired) begin
            status_expected.push_back(commutate(in_bus.mode, in_bus.hall_bits));
            beats_accepted++;
        end
        if (out_fired) begin
            got = '{out_bus.override_word, out_bus.period_average, out_bus.speed_value,
                    out_bus.speed_valid, out_bus.revolution_done};
            if (status_expected.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("%0t: result beat with nothing expected", $realtime);
                end
            end else begin
                want = status_expected.pop_front();
                results_checked++;
                if (want.revolution_done) begin
                    captures_seen++;
                end
                if (got.override_word !== want.override_word
                        || got.period_average !== want.period_average
                        || got.speed_value !== want.speed_value
                        || got.speed_valid !== want.speed_valid
                        || got.revolution_done !== want.revolution_done) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT) begin
                        $display("%0t: result %0d expected ovr=%h avg=%0d spd=%0d ok=%b rev=%b",
                                 $realtime, results_checked, want.override_word,
                                 want.period_average, want.speed_value, want.speed_valid,
                                 want.revolution_done);
                        $display("%0t: result %0d actual   ovr=%h avg=%0d spd=%0d ok=%b rev=%b",
                                 $realtime, results_checked, got.override_word,
                                 got.period_average, got.speed_value, got.speed_valid,
                                 got.revolution_done);
                    end
                end
            end
        end
        if (in_fired || out_fired || cfg_fired) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("No beat moved for %0d cycles, giving up.", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Input driver: holds a beat until it is taken, then waits out the next beat's gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!(in_bus.valid && !in_fired)) begin
            if (!drv_staged && beat_queue.size() != 0) begin
                staged_beat = beat_queue.pop_front();
                drv_staged  = 1'b1;
                gap_left    = staged_beat.gap;
            end
            if (drv_staged && gap_left == 0) begin
                in_bus.valid     <= 1'b1;
                in_bus.mode      <= staged_beat.mode;
                in_bus.hall_bits <= staged_beat.hall;
                drv_staged = 1'b0;
            end else begin
                in_bus.valid <= 1'b0;
                if (drv_staged) begin
                    gap_left--;
                end
            end
        end
    end

    // Result side: after each beat, stall the next result for a drawn number of cycles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_fired) begin
                stall_left = steady_flow ? 0 : $urandom_range(0, 4);
            end
            out_bus.ready <= (stall_left == 0);
            if (out_bus.valid && stall_left != 0) begin
                stall_left--;
            end
        end
    end

    task automatic queue_beat(input logic mode, input logic [HALL_W-1:0] hall);
        hall_beat_t b;
        b.mode = mode;
        b.hall = hall;
        b.gap  = steady_flow ? 3'd0 : 3'($urandom_range(0, 4));
        beat_queue.push_back(b);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic configure(input logic dir, input logic [PP_W-1:0] pp,
                             input logic [HALL_W-1:0] idx, input logic [SPEED_W-1:0] k);
        write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
        write_reg(REG_POLE_PAIRS, CFG_DATA_W'(pp));
        write_reg(REG_INDEX_POSITION, CFG_DATA_W'(idx));
        write_reg(REG_SPEED_CONSTANT, CFG_DATA_W'(k));
    endtask

    // Waits until every queued beat has gone in and every result has come back.
    task automatic settle_block();
        while (beat_queue.size() != 0 || drv_staged || in_bus.valid
               || status_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly a rotor turning one way with random tick counts between edges, with the
    // odd extra index visit, stray code or sudden reversal mixed in.
    task automatic queue_motion(input int steps, input int max_ticks);
        int pos;
        int dirn;
        int pick;
        pos  = $urandom_range(0, 5);
        dirn = $urandom_range(0, 1) ? 1 : 5;
        for (int s = 0; s < steps; s++) begin
            pick = $urandom_range(0, 99);
            repeat ($urandom_range(0, max_ticks)) queue_beat(MODE_TICK, HALL_W'($urandom));
            if (pick < 80) begin
                pos = (pos + dirn) % 6;
                queue_beat(MODE_HALL, ROTATION[pos*HALL_W +: HALL_W]);
            end else if (pick < 90) begin
                queue_beat(MODE_HALL, cfg_index_code);
            end else if (pick < 97) begin
                queue_beat(MODE_HALL, HALL_W'($urandom));
            end else begin
                pos  = $urandom_range(0, 5);
                dirn = 6 - dirn;
            end
        end
    endtask

    task automatic queue_index_visits(input int visits);
        for (int v = 0; v < visits; v++) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_beat(MODE_TICK, HALL_W'($urandom));
            end
            queue_beat(MODE_HALL, cfg_index_code);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.mode       = MODE_TICK;
        in_bus.hall_bits  = '0;
        out_bus.ready     = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_DIRECTION;
        cfg_bus.data      = '0;
        cfg_dir           = DIR_CW;
        cfg_pole_pairs    = 8'd2;
        cfg_index_code    = 3'd1;
        cfg_speed_k       = K_DEFAULT;
        tick_count        = '0;
        visit_count       = 8'd1;
        avg_period        = '0;
        speed_hold        = '0;
        drive_word        = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: every hall code, a zero-average capture, then a real one.
        queue_beat(MODE_TICK, 3'd7);
        queue_beat(MODE_HALL, 3'd0);
        queue_beat(MODE_HALL, 3'd7);
        for (int h = 2; h <= 6; h++) begin
            queue_beat(MODE_HALL, HALL_W'(h));
        end
        queue_beat(MODE_HALL, 3'd1);
        queue_beat(MODE_HALL, 3'd1);
        repeat (5) queue_beat(MODE_TICK, HALL_W'($urandom));
        queue_beat(MODE_HALL, 3'd1);
        queue_beat(MODE_HALL, 3'd1);
        settle_block();

        // Spare data bits set, and writes to indexes that do not exist.
        write_reg(REG_DIRECTION, 24'hABCDE1);
        write_reg(REG_POLE_PAIRS, 24'h3F0101);
        write_reg(REG_INDEX_POSITION, 24'hFFFFFE);
        write_reg(REG_SPEED_CONSTANT, K_MAX);
        write_reg(REG_SPARE_LO, 24'h000000);
        write_reg(REG_SPARE_HI, 24'hFFFFFF);
        for (int h = 0; h < 8; h++) begin
            queue_beat(MODE_HALL, HALL_W'(h));
        end

        // Longer revolutions with no idling: a long period, then a shorter one.
        steady_flow = 1'b1;
        repeat (3) queue_beat(MODE_TICK, HALL_W'($urandom));
        queue_beat(MODE_HALL, cfg_index_code);
        repeat (150) queue_beat(MODE_TICK, HALL_W'($urandom));
        queue_beat(MODE_HALL, cfg_index_code);
        repeat (60) queue_beat(MODE_TICK, HALL_W'($urandom));
        queue_beat(MODE_HALL, cfg_index_code);
        settle_block();

        for (int p = 0; p < 8; p++) begin
            steady_flow = (p % 3 == 2);
            case (p)
                0: configure(DIR_CW, 8'd1, 3'd1, K_DEFAULT);
                1: configure(DIR_ACW, 8'd3, 3'd5, '0);
                2: configure(DIR_CW, 8'd2, 3'd0, K_MAX);
                3: configure(DIR_ACW, 8'd1, 3'd7, SPEED_W'($urandom));
                default: begin
                    configure(1'($urandom), PP_W'($urandom_range(1, 4)),
                              HALL_W'($urandom_range(0, 7)), SPEED_W'($urandom));
                end
            endcase
            if (p == 5) begin
                queue_motion(4, 80);
            end else begin
                queue_motion(12, 6);
            end
            settle_block();
        end

        // Largest pole pair count, then zero, which counts all the way round to 256.
        steady_flow = 1'b0;
        configure(DIR_CW, 8'd255, 3'd3, SPEED_W'($urandom));
        queue_index_visits(260);
        settle_block();
        configure(DIR_ACW, 8'd0, 3'd4, K_MAX);
        queue_index_visits(270);
        settle_block();

        repeat (SETTLE) @(posedge i_clk);
        if (status_expected.size() != 0) begin
            $display("%0d expected results never arrived", status_expected.size());
            fault_count += status_expected.size();
        end
        $display("Run covered %0d input beats and %0d results, %0d of them revolution captures,",
                 beats_accepted, results_checked, captures_seen);
        $display("across %0d register writes; %0d faults seen.", cfg_writes, fault_count);
        if (fault_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/hcsm_pkg.sv
rtl/hcsm_if.sv
rtl/hall_commutation_speed_meter_top.sv
verif/testbench.sv
